/* sv/rlb_pkg.sv */
// ----------------------------------------------------------------------------
// rlb_pkg
// Shared constants, types and helper functions for the RGB LED breathing and
// rainbow effect generator.
// ----------------------------------------------------------------------------
package rlb_pkg;

    // effect sizing
    localparam int BREATH_STEPS       = 256;
    localparam int BREATH_COLOR_COUNT = 6;
    localparam int STEP_W             = $clog2(BREATH_STEPS);
    localparam int SEL_W              = 3;
    localparam int NUM_COLORS         = 6;

    // config port geometry
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_MODE   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_BRIGHT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_COLOR0 = 3'd2;

    // effect modes
    localparam int MODE_W = 2;
    localparam logic [MODE_W-1:0] MODE_NONE      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PULSE     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HUE_SWEEP = 2'd2;

    // reset value of the rainbow brightness
    localparam logic [7:0] BRIGHT_RESET = 8'd13;

    // update periods in ms
    localparam logic [31:0] BREATH_PERIOD_MS  = 32'd6;
    localparam logic [31:0] RAINBOW_PERIOD_MS = 32'd20;

    // breathing peak brightness and hue sweep
    localparam logic [7:0] BREATH_PEAK = 8'd70;
    localparam logic [8:0] HUE_STEP    = 9'd2;
    localparam logic [8:0] HUE_WRAP    = 9'd360;
    localparam logic [7:0] FULL_DUTY   = 8'd255;

    // table index = step * 256 / BREATH_STEPS, by reciprocal multiply
    localparam int IDX_SH     = 20;
    localparam int IDX_MUL    = ((1 << 28) + BREATH_STEPS - 1) / BREATH_STEPS;
    localparam int IDX_PROD_W = STEP_W + $clog2(IDX_MUL + 1);

    // x / 255 for 16-bit x, exact by reciprocal multiply
    localparam logic [16:0] DIV255_MUL = 17'd32897;
    localparam int          DIV255_SH  = 23;

    typedef logic [23:0] t_colors [NUM_COLORS];

    // controller to datapath commands
    typedef struct packed {
        logic load_now;
        logic upd_breath;
        logic upd_hue;
        logic do_idx;
        logic do_sine;
        logic do_brt;
        logic do_hsv;
        logic do_mul;
        logic do_div;
        logic out_load;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic breath_due;
        logic rainbow_due;
        logic out_busy;
    } t_dp_sts;

    // quarter-period-shifted sine, 0..255
    localparam logic [7:0] SINE_LUT [256] = '{
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,   8'd2,
        8'd2,   8'd3,   8'd4,   8'd5,   8'd5,   8'd6,   8'd7,   8'd9,
        8'd10,  8'd11,  8'd12,  8'd14,  8'd15,  8'd17,  8'd18,  8'd20,
        8'd21,  8'd23,  8'd25,  8'd27,  8'd29,  8'd31,  8'd33,  8'd35,
        8'd37,  8'd40,  8'd42,  8'd44,  8'd47,  8'd49,  8'd52,  8'd54,
        8'd57,  8'd59,  8'd62,  8'd65,  8'd67,  8'd70,  8'd73,  8'd76,
        8'd79,  8'd82,  8'd85,  8'd88,  8'd91,  8'd94,  8'd97,  8'd100,
        8'd103, 8'd106, 8'd109, 8'd112, 8'd115, 8'd118, 8'd121, 8'd124,
        8'd127, 8'd131, 8'd134, 8'd137, 8'd140, 8'd143, 8'd146, 8'd149,
        8'd152, 8'd155, 8'd158, 8'd161, 8'd164, 8'd167, 8'd170, 8'd173,
        8'd176, 8'd179, 8'd182, 8'd185, 8'd188, 8'd190, 8'd193, 8'd196,
        8'd198, 8'd201, 8'd203, 8'd206, 8'd208, 8'd211, 8'd213, 8'd215,
        8'd218, 8'd220, 8'd222, 8'd224, 8'd226, 8'd228, 8'd230, 8'd232,
        8'd234, 8'd236, 8'd238, 8'd239, 8'd241, 8'd243, 8'd244, 8'd246,
        8'd247, 8'd248, 8'd249, 8'd251, 8'd252, 8'd253, 8'd253, 8'd254,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd254, 8'd253, 8'd253, 8'd252, 8'd251, 8'd249,
        8'd248, 8'd247, 8'd246, 8'd244, 8'd243, 8'd241, 8'd239, 8'd238,
        8'd236, 8'd234, 8'd232, 8'd230, 8'd228, 8'd226, 8'd224, 8'd222,
        8'd220, 8'd218, 8'd215, 8'd213, 8'd211, 8'd208, 8'd206, 8'd203,
        8'd201, 8'd198, 8'd196, 8'd193, 8'd190, 8'd188, 8'd185, 8'd182,
        8'd179, 8'd176, 8'd173, 8'd170, 8'd167, 8'd164, 8'd161, 8'd158,
        8'd155, 8'd152, 8'd149, 8'd146, 8'd143, 8'd140, 8'd137, 8'd134,
        8'd131, 8'd127, 8'd124, 8'd121, 8'd118, 8'd115, 8'd112, 8'd109,
        8'd106, 8'd103, 8'd100, 8'd97,  8'd94,  8'd91,  8'd88,  8'd85,
        8'd82,  8'd79,  8'd76,  8'd73,  8'd70,  8'd67,  8'd65,  8'd62,
        8'd59,  8'd57,  8'd54,  8'd52,  8'd49,  8'd47,  8'd44,  8'd42,
        8'd40,  8'd37,  8'd35,  8'd33,  8'd31,  8'd29,  8'd27,  8'd25,
        8'd23,  8'd21,  8'd20,  8'd18,  8'd17,  8'd15,  8'd14,  8'd12,
        8'd11,  8'd10,  8'd9,   8'd7,   8'd6,   8'd5,   8'd5,   8'd4,
        8'd3,   8'd2,   8'd2,   8'd1,   8'd1,   8'd0,   8'd0,   8'd0
    };

    // x / 255 for x up to 65279
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [32:0] p;
        p = 33'(x) * 33'(DIV255_MUL);
        return p[DIV255_SH +: 8];
    endfunction

endpackage

/* sv/rlb_in_if.sv */
// ----------------------------------------------------------------------------
// rlb_in_if
// Timestamp channel: one millisecond time value per transfer.
// ----------------------------------------------------------------------------
interface rlb_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_ms;

    modport source (output valid, output now_ms, input ready);
    modport sink   (input valid, input now_ms, output ready);
endinterface

/* sv/rlb_out_if.sv */
// ----------------------------------------------------------------------------
// rlb_out_if
// Duty channel: one set of RGB PWM duties per transfer.
// ----------------------------------------------------------------------------
interface rlb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_duty;
    logic [7:0] green_duty;
    logic [7:0] blue_duty;

    modport source (output valid, output red_duty, output green_duty,
                    output blue_duty, input ready);
    modport sink   (input valid, input red_duty, input green_duty,
                    input blue_duty, output ready);
endinterface

/* sv/rlb_regs.sv */
// ----------------------------------------------------------------------------
// rlb_regs
// APB-style register file: effect mode, rainbow brightness, six colors.
// ----------------------------------------------------------------------------
module rlb_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rlb_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [rlb_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [rlb_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output logic [rlb_pkg::MODE_W-1:0]       o_mode,
    output logic [7:0]                       o_bright,
    output rlb_pkg::t_colors                 o_colors
);

    logic [rlb_pkg::MODE_W-1:0]    r_mode;
    logic [7:0]                    r_bright;
    rlb_pkg::t_colors              r_colors;
    logic [rlb_pkg::REG_IDX_W-1:0] reg_idx;
    logic [rlb_pkg::REG_IDX_W-1:0] col_idx;
    logic                          wr_en;

    // address decode
    assign reg_idx = paddr[rlb_pkg::APB_ADDR_W-1:2];
    assign col_idx = reg_idx - rlb_pkg::REG_COLOR0;
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= rlb_pkg::MODE_NONE;
            r_bright <= rlb_pkg::BRIGHT_RESET;
            for (int i = 0; i < rlb_pkg::NUM_COLORS; i++) begin
                r_colors[i] <= '0;
            end
        end else if (wr_en) begin
            unique case (reg_idx)
                rlb_pkg::REG_MODE:   r_mode   <= pwdata[rlb_pkg::MODE_W-1:0];
                rlb_pkg::REG_BRIGHT: r_bright <= pwdata[7:0];
                default:             r_colors[col_idx] <= pwdata[23:0];
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (reg_idx)
            rlb_pkg::REG_MODE:   prdata = rlb_pkg::APB_DATA_W'(r_mode);
            rlb_pkg::REG_BRIGHT: prdata = rlb_pkg::APB_DATA_W'(r_bright);
            default:             prdata = rlb_pkg::APB_DATA_W'(r_colors[col_idx]);
        endcase
    end

    assign o_mode   = r_mode;
    assign o_bright = r_bright;
    assign o_colors = r_colors;

endmodule

/* sv/rlb_dp.sv */
// ----------------------------------------------------------------------------
// rlb_dp
// Datapath: effect state, due check, sine and HSV color, scaling by 255ths,
// and the output register.
// ----------------------------------------------------------------------------
module rlb_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [31:0]          i_now_ms,
    input  rlb_pkg::t_dp_cmd     i_cmd,
    output rlb_pkg::t_dp_sts     o_sts,
    input  logic [7:0]           i_bright,
    input  rlb_pkg::t_colors     i_colors,
    rlb_out_if.source            o_duty
);

    // effect state
    logic [31:0]                 r_now;
    logic [31:0]                 r_last;
    logic [rlb_pkg::STEP_W-1:0]  r_step;
    logic [rlb_pkg::STEP_W-1:0]  n_step;
    logic [rlb_pkg::SEL_W-1:0]   r_sel;
    logic [rlb_pkg::SEL_W-1:0]   n_sel;
    logic [8:0]                  r_hue;
    logic [8:0]                  n_hue;

    // working registers
    logic [7:0]                  r_idx;
    logic [15:0]                 r_sp;
    logic [7:0]                  r_k;
    logic [2:0][7:0]             r_base;
    logic [2:0][15:0]            r_prod;
    logic [2:0][7:0]             r_q;
    logic [2:0][7:0]             r_duty;
    logic                        r_out_valid;

    logic [31:0]                 elapsed;
    logic [rlb_pkg::STEP_W:0]    step_inc;
    logic [rlb_pkg::SEL_W-1:0]   sel_inc;
    logic [9:0]                  hue_inc;
    logic [rlb_pkg::IDX_PROD_W-1:0] idx_prod;
    logic [23:0]                 col;
    logic [2:0]                  sector;
    logic [8:0]                  sector_base;
    logic [5:0]                  rem;
    logic [9:0]                  rem17;
    logic [7:0]                  f_up;
    logic [7:0]                  f_dn;
    logic [2:0][7:0]             hsv_rgb;

    // due check with wrapping subtraction
    assign elapsed           = r_now - r_last;
    assign o_sts.breath_due  = (elapsed >= rlb_pkg::BREATH_PERIOD_MS);
    assign o_sts.rainbow_due = (elapsed >= rlb_pkg::RAINBOW_PERIOD_MS);
    assign o_sts.out_busy    = r_out_valid & ~o_duty.ready;

    // breathing phase and color selector advance
    always_comb begin
        step_inc = {1'b0, r_step} + 1'b1;
        sel_inc  = r_sel + 1'b1;
        n_step   = step_inc[rlb_pkg::STEP_W-1:0];
        n_sel    = r_sel;
        if (step_inc >= (rlb_pkg::STEP_W + 1)'(rlb_pkg::BREATH_STEPS)) begin
            n_step = '0;
            if (sel_inc >= rlb_pkg::SEL_W'(rlb_pkg::BREATH_COLOR_COUNT)) begin
                n_sel = '0;
            end else begin
                n_sel = sel_inc;
            end
        end
    end

    // hue advance modulo 360
    always_comb begin
        hue_inc = {1'b0, r_hue} + {1'b0, rlb_pkg::HUE_STEP};
        if (hue_inc >= {1'b0, rlb_pkg::HUE_WRAP}) begin
            hue_inc = hue_inc - {1'b0, rlb_pkg::HUE_WRAP};
        end
        n_hue = hue_inc[8:0];
    end

    // sine table index
    assign idx_prod = rlb_pkg::IDX_PROD_W'(r_step)
                    * rlb_pkg::IDX_PROD_W'(rlb_pkg::IDX_MUL);

    assign col = i_colors[r_sel];

    // hue sector by compare chain
    always_comb begin
        priority if (r_hue >= 9'd300) begin
            sector = 3'd5; sector_base = 9'd300;
        end else if (r_hue >= 9'd240) begin
            sector = 3'd4; sector_base = 9'd240;
        end else if (r_hue >= 9'd180) begin
            sector = 3'd3; sector_base = 9'd180;
        end else if (r_hue >= 9'd120) begin
            sector = 3'd2; sector_base = 9'd120;
        end else if (r_hue >= 9'd60) begin
            sector = 3'd1; sector_base = 9'd60;
        end else begin
            sector = 3'd0; sector_base = 9'd0;
        end
    end

    // fraction within sector: rem * 255 / 60 == rem * 17 / 4
    always_comb begin
        logic [8:0] diff;
        diff  = r_hue - sector_base;
        rem   = diff[5:0];
        rem17 = {4'd0, rem} * 10'd17;
        f_up  = rem17[9:2];
        f_dn  = rlb_pkg::FULL_DUTY - f_up;
    end

    // sector to rgb, index 2 red, 1 green, 0 blue
    always_comb begin
        unique case (sector)
            3'd0:    hsv_rgb = {rlb_pkg::FULL_DUTY, f_up, 8'd0};
            3'd1:    hsv_rgb = {f_dn, rlb_pkg::FULL_DUTY, 8'd0};
            3'd2:    hsv_rgb = {8'd0, rlb_pkg::FULL_DUTY, f_up};
            3'd3:    hsv_rgb = {8'd0, f_dn, rlb_pkg::FULL_DUTY};
            3'd4:    hsv_rgb = {f_up, 8'd0, rlb_pkg::FULL_DUTY};
            default: hsv_rgb = {rlb_pkg::FULL_DUTY, 8'd0, f_dn};
        endcase
    end

    // effect state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
            r_step <= '0;
            r_sel  <= '0;
            r_hue  <= '0;
        end else begin
            if (i_cmd.upd_breath) begin
                r_last <= r_now;
                r_step <= n_step;
                r_sel  <= n_sel;
            end
            if (i_cmd.upd_hue) begin
                r_last <= r_now;
                r_hue  <= n_hue;
            end
        end
    end

    // work stages
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_now) begin
            r_now <= i_now_ms;
        end
        if (i_cmd.do_idx) begin
            r_idx <= idx_prod[rlb_pkg::IDX_SH +: 8];
        end
        if (i_cmd.do_sine) begin
            r_sp <= 16'(rlb_pkg::SINE_LUT[r_idx]) * 16'(rlb_pkg::BREATH_PEAK);
        end
        if (i_cmd.do_brt) begin
            r_k    <= rlb_pkg::div255(r_sp);
            r_base <= col;
        end
        if (i_cmd.do_hsv) begin
            r_k    <= i_bright;
            r_base <= hsv_rgb;
        end
        for (int i = 0; i < 3; i++) begin
            if (i_cmd.do_mul) begin
                r_prod[i] <= 16'(r_base[i]) * 16'(r_k);
            end
            if (i_cmd.do_div) begin
                r_q[i] <= rlb_pkg::div255(r_prod[i]);
            end
        end
        if (i_cmd.out_load) begin
            r_duty <= r_q;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_duty.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_duty.valid      = r_out_valid;
    assign o_duty.red_duty   = r_duty[2];
    assign o_duty.green_duty = r_duty[1];
    assign o_duty.blue_duty  = r_duty[0];

    // hue stays on even degrees below 360
    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hue < rlb_pkg::HUE_WRAP) && !r_hue[0])
        else $error("hue left its range");

    // color selector stays within the color count
    a_sel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sel < rlb_pkg::SEL_W'(rlb_pkg::BREATH_COLOR_COUNT))
        else $error("color selector out of range");

    // a new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !(r_out_valid && !o_duty.ready))
        else $error("output register overwritten");

    // an update always moves the last update time to the sampled timestamp
    a_last_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.upd_breath || i_cmd.upd_hue) |=> (r_last == $past(r_now)))
        else $error("last update time not refreshed");

endmodule

/* sv/rlb_ctrl.sv */
// ----------------------------------------------------------------------------
// rlb_ctrl
// Controller: sequences one timestamp through due check and the breathing or
// rainbow datapath steps when one is due, then hands the result to the output register.
// ----------------------------------------------------------------------------
module rlb_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [rlb_pkg::MODE_W-1:0] i_mode,
    input  rlb_pkg::t_dp_sts           i_sts,
    output rlb_pkg::t_dp_cmd           o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_IDX   = 4'd2;
    localparam logic [3:0] S_SINE  = 4'd3;
    localparam logic [3:0] S_BRT   = 4'd4;
    localparam logic [3:0] S_HSV   = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_now = 1'b1;
                    n_state        = S_CHECK;
                end
            end
            S_CHECK: begin
                priority if (i_mode == rlb_pkg::MODE_PULSE && i_sts.breath_due) begin
                    o_cmd.upd_breath = 1'b1;
                    n_state          = S_IDX;
                end else if (i_mode == rlb_pkg::MODE_HUE_SWEEP && i_sts.rainbow_due) begin
                    o_cmd.upd_hue = 1'b1;
                    n_state       = S_HSV;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_IDX: begin
                o_cmd.do_idx = 1'b1;
                n_state      = S_SINE;
            end
            S_SINE: begin
                o_cmd.do_sine = 1'b1;
                n_state       = S_BRT;
            end
            S_BRT: begin
                o_cmd.do_brt = 1'b1;
                n_state      = S_MUL;
            end
            S_HSV: begin
                o_cmd.do_hsv = 1'b1;
                n_state      = S_MUL;
            end
            S_MUL: begin
                o_cmd.do_mul = 1'b1;
                n_state      = S_DIV;
            end
            S_DIV: begin
                o_cmd.do_div = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // the due check only ever follows a timestamp transfer
    a_check_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> $past(i_in_valid && o_in_ready))
        else $error("due check without a timestamp transfer");

    // results are produced only under an active effect mode
    a_upd_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.upd_breath || o_cmd.upd_hue)
            |-> (i_mode == rlb_pkg::MODE_PULSE || i_mode == rlb_pkg::MODE_HUE_SWEEP))
        else $error("update issued with no effect mode");

endmodule

/* sv/rgb_led_breath_rainbow_effect.sv */
// ----------------------------------------------------------------------------
// rgb_led_breath_rainbow_effect
// RGB LED breathing and HSV rainbow effect generator: one millisecond
// timestamp in, at most one set of PWM duties out per timestamp.
// ----------------------------------------------------------------------------
//  channel   direction  payload                               handshake
//  i_tick    in         now_ms[31:0]                          valid/ready
//  o_duty    out        red_duty, green_duty, blue_duty [7:0] valid/ready
//  apb       in/out     paddr[4:2] selects register 0..7      psel/penable
//
//  a timestamp that brings no update returns to idle after the due check
//  breathing updates walk the controller's index, sine, scale, multiply and
//  divide-by-255 steps, rainbow updates its HSV, multiply and divide steps
//  synchronous active-low reset clears effect state and config registers
//  a stalled o_duty holds the result; i_tick is taken again once the
//  result sits in the output register
// ----------------------------------------------------------------------------
module rgb_led_breath_rainbow_effect (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    rlb_in_if.sink                           i_tick,
    rlb_out_if.source                        o_duty,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rlb_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [rlb_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [rlb_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    logic [rlb_pkg::MODE_W-1:0] mode;
    logic [7:0]                 bright;
    rlb_pkg::t_colors           colors;
    rlb_pkg::t_dp_cmd           dp_cmd;
    rlb_pkg::t_dp_sts           dp_sts;
    logic                       in_ready;

    // configuration registers
    rlb_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_mode   (mode),
        .o_bright (bright),
        .o_colors (colors)
    );

    // sequencer
    rlb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_tick.valid),
        .o_in_ready (in_ready),
        .i_mode     (mode),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    assign i_tick.ready = in_ready;

    // datapath and output register
    rlb_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_now_ms (i_tick.now_ms),
        .i_cmd    (dp_cmd),
        .o_sts    (dp_sts),
        .i_bright (bright),
        .i_colors (colors),
        .o_duty   (o_duty)
    );

endmodule
